// ----- design/spr_pkg.sv -----
`default_nettype none

package spr_pkg;

    localparam int MAX_PATTERN_DEF = 8;
    localparam int CMD_BYTES       = 8;
    localparam int CMD_CNT_W       = 4;
    localparam int QUEUE_DEPTH     = 4;
    localparam int APB_ADDR_W      = 5;
    localparam int APB_DATA_W      = 64;

    localparam logic [7:0] NEWLINE = 8'h0A;

    typedef enum logic [1:0] {
        REG_PAT_BYTES = 2'd0,
        REG_PAT_LEN   = 2'd1,
        REG_REP_BYTES = 2'd2,
        REG_REP_LEN   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       line_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    // bytes to emit, first byte in the lowest lane
    typedef struct packed {
        logic [8*CMD_BYTES-1:0] bytes;
        logic [CMD_CNT_W-1:0]   cnt;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

// ----- design/spr_front.sv -----
`default_nettype none

module spr_front #(
    parameter int MAX_PATTERN = spr_pkg::MAX_PATTERN_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  spr_pkg::t_in_item   i_item,
    input  wire [63:0]          i_pat_bytes,
    input  wire [3:0]           i_pat_len,
    input  wire [63:0]          i_rep_bytes,
    input  wire [3:0]           i_rep_len,
    input  spr_pkg::t_q_stat    i_q_stat,
    output logic                o_push,
    output spr_pkg::t_cmd       o_cmd
);

    localparam int CW = $clog2(MAX_PATTERN + 1);

    logic [7:0]    r_win [MAX_PATTERN];
    logic [7:0]    n_win [MAX_PATTERN];
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic [7:0]    ext   [MAX_PATTERN];
    logic          accept;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (o_cmd.cnt != '0);

    always_comb begin
        int         n;
        int         d_sel;
        int         len;
        int         plen;
        logic       hit;
        logic       found;
        logic       full_hit;
        logic [3:0] rlen;

        if (i_pat_len == 4'd0) begin
            plen = 1;
        end else if (int'(i_pat_len) > MAX_PATTERN) begin
            plen = MAX_PATTERN;
        end else begin
            plen = int'(i_pat_len);
        end
        rlen = (i_rep_len > 4'd8) ? 4'd8 : i_rep_len;
        n    = int'(r_cnt) + 1;

        for (int j = 0; j < MAX_PATTERN; j++) begin
            ext[j] = (j < int'(r_cnt)) ? r_win[j] : i_item.in_byte;
        end

        full_hit = (n == plen);
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (i < n && ext[i] != i_pat_bytes[8*i +: 8]) begin
                full_hit = 1'b0;
            end
        end

        // smallest drop count that leaves a proper prefix of the pattern
        found = 1'b0;
        d_sel = n;
        for (int d = 0; d <= MAX_PATTERN; d++) begin
            len = n - d;
            hit = (d <= n) && (len < plen);
            for (int i = 0; i < MAX_PATTERN; i++) begin
                if (i < len && d + i < MAX_PATTERN) begin
                    if (ext[d + i] != i_pat_bytes[8*i +: 8]) begin
                        hit = 1'b0;
                    end
                end
            end
            if (hit && !found) begin
                found = 1'b1;
                d_sel = d;
            end
        end

        o_cmd = '0;
        n_win = r_win;
        n_cnt = r_cnt;
        if (i_item.line_end) begin
            for (int j = 0; j < spr_pkg::CMD_BYTES; j++) begin
                if (j < int'(r_cnt) && j < MAX_PATTERN) begin
                    o_cmd.bytes[8*j +: 8] = r_win[j];
                end else if (j == int'(r_cnt)) begin
                    o_cmd.bytes[8*j +: 8] = spr_pkg::NEWLINE;
                end
            end
            o_cmd.cnt = spr_pkg::CMD_CNT_W'(n);
            n_cnt     = '0;
        end else if (full_hit) begin
            o_cmd.bytes = i_rep_bytes;
            o_cmd.cnt   = rlen;
            n_cnt       = '0;
        end else begin
            for (int j = 0; j < spr_pkg::CMD_BYTES; j++) begin
                if (j < d_sel && j < MAX_PATTERN) begin
                    o_cmd.bytes[8*j +: 8] = ext[j];
                end
            end
            o_cmd.cnt = spr_pkg::CMD_CNT_W'(d_sel);
            for (int j = 0; j < MAX_PATTERN; j++) begin
                n_win[j] = (j + d_sel < MAX_PATTERN) ? ext[j + d_sel] : ext[j];
            end
            n_cnt = CW'(n - d_sel);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ----- design/spr_queue.sv -----
`default_nettype none

module spr_queue #(
    parameter int DEPTH = spr_pkg::QUEUE_DEPTH
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  spr_pkg::t_cmd       i_cmd,
    input  wire                 i_pop,
    output spr_pkg::t_cmd       o_head,
    output spr_pkg::t_q_stat    o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    spr_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [NW-1:0] r_num;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_num == NW'(DEPTH));
    assign o_stat.empty = (r_num == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_num <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_num <= r_num + 1'b1;
            end else if (i_pop && !i_push) begin
                r_num <= r_num - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/spr_back.sv -----
`default_nettype none

module spr_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  spr_pkg::t_cmd       i_head,
    input  spr_pkg::t_q_stat    i_q_stat,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output spr_pkg::t_out_item  o_item
);

    logic [8*spr_pkg::CMD_BYTES-1:0] r_work;
    logic [spr_pkg::CMD_CNT_W-1:0]   r_left;
    logic                            r_out_valid;
    spr_pkg::t_out_item              r_out;

    logic                            busy;
    logic                            load_out;
    logic                            src_valid;
    logic                            emit;
    logic [8*spr_pkg::CMD_BYTES-1:0] src_bytes;
    logic [spr_pkg::CMD_CNT_W-1:0]   src_left;

    assign busy      = (r_left != '0);
    assign load_out  = !r_out_valid || i_ready;
    assign src_valid = busy || !i_q_stat.empty;
    assign emit      = load_out && src_valid;
    assign src_bytes = busy ? r_work : i_head.bytes;
    assign src_left  = busy ? r_left : i_head.cnt;
    assign o_pop     = emit && !busy;
    assign o_valid   = r_out_valid;
    assign o_item    = r_out;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_work       <= src_bytes >> 8;
            r_out.out_byte <= src_bytes[7:0];
            r_out.last     <= (src_left == spr_pkg::CMD_CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_left <= src_left - 1'b1;
            end
            if (load_out) begin
                r_out_valid <= src_valid;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/stream_pattern_replacer.sv -----
`default_nettype none

// Streaming find-and-replace. Takes one text byte or line-end marker per
// transaction and one input transaction per cycle; each input may release up to
// 8 output bytes, which leave one per cycle from the output register when i_ready
// is high, so sustained input rate is one per cycle while each input produces at
// most one byte on average. A 4-entry command queue between the matcher and the
// output serializer absorbs bursts; input ready drops only when that queue is
// full. Registers (64-bit APB, byte address 8*i): pattern bytes, pattern length,
// replacement bytes, replacement length. Write them only while the block is idle.
module stream_pattern_replacer #(
    parameter int MAX_PATTERN = spr_pkg::MAX_PATTERN_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  spr_pkg::t_in_item                  i_data,
    output logic                               o_valid,
    input  wire                                i_ready,
    output spr_pkg::t_out_item                 o_data,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [spr_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire [spr_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [spr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    logic [63:0] r_pat_bytes;
    logic [3:0]  r_pat_len;
    logic [63:0] r_rep_bytes;
    logic [3:0]  r_rep_len;

    spr_pkg::t_reg_idx reg_idx;
    logic              cfg_wr;
    logic              push;
    logic              pop;
    spr_pkg::t_cmd     cmd;
    spr_pkg::t_cmd     head;
    spr_pkg::t_q_stat  q_stat;

    assign pready  = 1'b1;
    assign reg_idx = spr_pkg::t_reg_idx'(paddr[4:3]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (reg_idx)
            spr_pkg::REG_PAT_BYTES: prdata = r_pat_bytes;
            spr_pkg::REG_PAT_LEN:   prdata = {60'd0, r_pat_len};
            spr_pkg::REG_REP_BYTES: prdata = r_rep_bytes;
            spr_pkg::REG_REP_LEN:   prdata = {60'd0, r_rep_len};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_bytes <= '0;
            r_pat_len   <= 4'd1;
            r_rep_bytes <= '0;
            r_rep_len   <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                spr_pkg::REG_PAT_BYTES: r_pat_bytes <= pwdata;
                spr_pkg::REG_PAT_LEN:   r_pat_len   <= pwdata[3:0];
                spr_pkg::REG_REP_BYTES: r_rep_bytes <= pwdata;
                spr_pkg::REG_REP_LEN:   r_rep_len   <= pwdata[3:0];
                default:                ;
            endcase
        end
    end

    spr_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_data),
        .i_pat_bytes (r_pat_bytes),
        .i_pat_len   (r_pat_len),
        .i_rep_bytes (r_rep_bytes),
        .i_rep_len   (r_rep_len),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_cmd       (cmd)
    );

    spr_queue #(
        .DEPTH (spr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    spr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_item   (o_data)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("command queue underflow");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && q_stat.empty)
        else $error("output or queue not idle after reset");

    a_newline_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && head.cnt == 4'd1 |=> o_valid && o_data.last)
        else $error("single-byte command not marked last");

endmodule

`default_nettype wire

// ----- bench/spr_checker.sv -----
`timescale 1ns / 1ps

module spr_checker
    import spr_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  wire                  o_ready,
    input  t_in_item             i_data,
    input  wire                  o_valid,
    input  wire                  i_ready,
    input  t_out_item            o_data,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire [APB_ADDR_W-1:0] paddr,
    input  wire [APB_DATA_W-1:0] pwdata,
    input  wire                  pready,
    output int                   fail_count,
    output int                   outstanding
);

    logic [63:0] pat_bytes = '0;
    logic [3:0]  pat_len   = 4'd1;
    logic [63:0] rep_bytes = '0;
    logic [3:0]  rep_len   = '0;

    logic [7:0]  window [MAX_PATTERN_DEF];
    int          window_cnt = 0;
    t_out_item   expected_text [$];
    int          mismatches = 0;
    int          queued     = 0;

    assign fail_count  = mismatches;
    assign outstanding = queued;

    function automatic logic prefix_ok(int k);
        for (int i = 0; i < k && i < MAX_PATTERN_DEF; i++) begin
            if (window[i] != pat_bytes[8*i +: 8])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void push_char(logic [7:0] b);
        t_out_item e;
        e.out_byte = b;
        e.last     = 1'b0;
        expected_text.push_back(e);
    endfunction

    function automatic void replace_step(t_in_item it);
        int        plen;
        int        rlen;
        int        n_before;
        t_out_item tail;
        n_before = expected_text.size();
        if (it.line_end) begin
            for (int i = 0; i < window_cnt; i++)
                push_char(window[i]);
            window_cnt = 0;
            push_char(NEWLINE);
        end else begin
            plen = (pat_len == 0) ? 1 :
                   (pat_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(pat_len);
            window[window_cnt] = it.in_byte;
            window_cnt++;
            if (window_cnt == plen && prefix_ok(window_cnt)) begin
                rlen = (rep_len > 8) ? 8 : int'(rep_len);
                for (int i = 0; i < rlen; i++)
                    push_char(rep_bytes[8*i +: 8]);
                window_cnt = 0;
            end else begin
                // drop the oldest byte until the rest is a proper prefix again
                while (!(window_cnt < plen && prefix_ok(window_cnt))) begin
                    push_char(window[0]);
                    for (int i = 1; i < window_cnt; i++)
                        window[i-1] = window[i];
                    window_cnt--;
                end
            end
        end
        if (expected_text.size() > n_before) begin
            tail = expected_text.pop_back();
            tail.last = 1'b1;
            expected_text.push_back(tail);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            pat_bytes  = '0;
            pat_len    = 4'd1;
            rep_bytes  = '0;
            rep_len    = '0;
            window_cnt = 0;
            expected_text.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[APB_ADDR_W-1:3]))
                    REG_PAT_BYTES: pat_bytes = pwdata;
                    REG_PAT_LEN:   pat_len   = pwdata[3:0];
                    REG_REP_BYTES: rep_bytes = pwdata;
                    REG_REP_LEN:   rep_len   = pwdata[3:0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready)
                replace_step(i_data);
            if (o_valid && i_ready) begin
                if (expected_text.size() == 0) begin
                    $error("out_byte: no transaction expected, got %02h", o_data.out_byte);
                    mismatches++;
                end else begin
                    want = expected_text.pop_front();
                    if (o_data.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %02h, got %02h",
                               want.out_byte, o_data.out_byte);
                        mismatches++;
                    end
                    if (o_data.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, o_data.last);
                        mismatches++;
                    end
                end
            end
        end
        queued = expected_text.size();
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import spr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int PHASE_ITEMS    = 52;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    t_in_item              i_data  = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    t_out_item             o_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int          fail_count;
    int          outstanding;
    int          quiet = 0;
    logic        calm  = 1'b0;
    logic [63:0] stim_pat;
    int          stim_plen;

    stream_pattern_replacer dut (.*);

    spr_checker replace_check (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) ||
            (psel && penable && pwrite && pready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        @(posedge i_clk);
        forever begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(30, 80)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            if (!calm) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // length registers get garbage in the unused upper bits
    task automatic set_config(logic [63:0] pb, logic [3:0] pl, logic [63:0] rb, logic [3:0] rl);
        write_reg(REG_PAT_BYTES, pb);
        write_reg(REG_PAT_LEN, {$urandom(), 28'($urandom()), pl});
        write_reg(REG_REP_BYTES, rb);
        write_reg(REG_REP_LEN, {$urandom(), 28'($urandom()), rl});
        stim_pat  = pb;
        stim_plen = (pl == 0) ? 1 : (pl > 8) ? 8 : int'(pl);
    endtask

    task automatic send(logic [7:0] b, logic le);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{in_byte: b, line_end: le};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send(s[i], 1'b0);
    endtask

    task automatic send_eol();
        send(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [63:0] text_pattern();
        logic [63:0] v;
        for (int i = 0; i < 8; i++)
            v[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 2));
        return v;
    endfunction

    // mostly whole or partial pattern occurrences, with noise and line ends
    task automatic random_phase(int count);
        int sent;
        int r;
        int k;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                for (int i = 0; i < stim_plen; i++)
                    send(stim_pat[8*i +: 8], 1'b0);
                sent += stim_plen;
            end else if (r < 55) begin
                k = $urandom_range(1, stim_plen);
                for (int i = 0; i < k; i++)
                    send(stim_pat[8*i +: 8], 1'b0);
                sent += k;
            end else if (r < 80) begin
                k = $urandom_range(0, stim_plen - 1);
                send(stim_pat[8*k +: 8], 1'b0);
                sent++;
            end else if (r < 93) begin
                send(8'($urandom_range(0, 255)), 1'b0);
                sent++;
            end else begin
                send_eol();
                sent++;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // "abc" -> "XYZW"
        set_config(64'h0000_0000_0063_6261, 4'd3, 64'h0000_0000_575A_5958, 4'd4);
        send_text("xabcx");
        send_eol();
        send_text("aabab");
        send_eol();
        send_eol();
        send_text("ab");
        send(NEWLINE, 1'b0);
        send_text("c");
        send(8'h00, 1'b0);
        send(8'hFF, 1'b0);
        send_text("abcab");
        wait_idle();
        // pattern swapped with "ab" still pending
        set_config(64'h0000_0000_0000_7A62, 4'd2, 64'h0000_0000_0000_0051, 4'd1);
        send_text("z");
        send_eol();
        wait_idle();

        set_config(text_pattern(), 4'd0, {$urandom(), $urandom()}, 4'd15);
        random_phase(PHASE_ITEMS);
        wait_idle();
        set_config('1, 4'd8, {$urandom(), $urandom()}, 4'd0);
        random_phase(PHASE_ITEMS);
        wait_idle();
        set_config(text_pattern(), 4'd15, {$urandom(), $urandom()}, 4'd8);
        random_phase(PHASE_ITEMS);
        wait_idle();
        set_config('0, 4'd1, '1, 4'd1);
        random_phase(PHASE_ITEMS);
        wait_idle();
        repeat (4) begin
            set_config(text_pattern(), 4'($urandom_range(0, 15)), {$urandom(), $urandom()},
                       4'($urandom_range(0, 15)));
            random_phase(PHASE_ITEMS);
            wait_idle();
        end

        calm = 1'b1;
        set_config(text_pattern(), 4'd2, {$urandom(), $urandom()}, 4'd3);
        random_phase(PHASE_ITEMS);
        send_eol();
        wait_idle();

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
design/spr_pkg.sv
design/spr_front.sv
design/spr_queue.sv
design/spr_back.sv
design/stream_pattern_replacer.sv
bench/spr_checker.sv
bench/tb.sv
